/* src/r2nv_pkg.sv */
// Shared types, constants and helpers for the RGB to NV12 pixel converter.
package r2nv_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_FORMAT = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_BGRA   = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

  // c*255/31 and c*255/63 as one multiply by a scaled reciprocal, >> 20
  localparam logic [28:0] EXP5_MUL = 29'd8625630;
  localparam logic [28:0] EXP6_MUL = 29'd4244475;
  localparam int unsigned EXP_SHIFT = 20;

  // BT.601 coefficients
  localparam logic [17:0] Y_R  = 18'd66;
  localparam logic [17:0] Y_G  = 18'd129;
  localparam logic [17:0] Y_B  = 18'd25;
  localparam logic [17:0] CB_R = 18'd38;
  localparam logic [17:0] CB_G = 18'd74;
  localparam logic [17:0] CB_B = 18'd112;
  localparam logic [17:0] CR_R = 18'd112;
  localparam logic [17:0] CR_G = 18'd94;
  localparam logic [17:0] CR_B = 18'd18;
  localparam logic [17:0] ROUND_OFS  = 18'd128;
  localparam logic [17:0] CHROMA_OFS = 18'd32896;  // 128 + 128*256

  localparam logic [7:0] LUMA_MIN   = 8'd16;
  localparam logic [7:0] LUMA_MAX   = 8'd235;
  localparam logic [7:0] CHROMA_MIN = 8'd16;
  localparam logic [7:0] CHROMA_MAX = 8'd240;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic chroma;
    logic frame_end;
  } pos_flags_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [28:0] prod;
    prod = 29'(c) * EXP5_MUL;
    return prod[EXP_SHIFT +: 8];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [28:0] prod;
    prod = 29'(c) * EXP6_MUL;
    return prod[EXP_SHIFT +: 8];
  endfunction

endpackage

/* src/r2nv_if.sv */
// Handshake channel interfaces: pixel input, converted output, config write.
interface r2nv_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [r2nv_pkg::PIXEL_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface r2nv_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;
  logic       frame_end;

  modport source (output valid, output luma, output chroma_valid, output chroma_blue,
                  output chroma_red, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input chroma_blue,
                  input chroma_red, input frame_end, output ready);
endinterface

interface r2nv_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [r2nv_pkg::CFG_IDX_W-1:0]  index;
  logic [r2nv_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/r2nv_pos_tracker.sv */
// Column/row position counters with chroma-site and end-of-frame flags.
module r2nv_pos_tracker #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [r2nv_pkg::SIZE_W-1:0]  frame_width,
  input  logic [r2nv_pkg::SIZE_W-1:0]  frame_height,
  output r2nv_pkg::pos_flags_t         flags
);
  import r2nv_pkg::*;

  localparam int unsigned POS_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned CMP_W = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;
  localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(MAX_DIMENSION);
  localparam logic [CMP_W-1:0] ONE      = CMP_W'(1);

  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] eff_w, eff_h, w_ext, h_ext;
  logic             col_last, row_last;

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    w_ext = CMP_W'(frame_width);
    h_ext = CMP_W'(frame_height);
    eff_w = (w_ext == '0) ? ONE : ((w_ext > MAX_SIZE) ? MAX_SIZE : w_ext);
    eff_h = (h_ext == '0) ? ONE : ((h_ext > MAX_SIZE) ? MAX_SIZE : h_ext);
    col_last = (CMP_W'(col_r) + ONE) >= eff_w;
    row_last = (CMP_W'(row_r) + ONE) >= eff_h;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign flags.chroma    = !col_r[0] && !row_r[0];
  assign flags.frame_end = col_last && row_last;

endmodule

/* src/r2nv_csc.sv */
// BT.601 limited-range RGB to YCbCr conversion with output clamping.
module r2nv_csc (
  input  r2nv_pkg::rgb_t rgb,
  input  logic           chroma,
  output r2nv_pkg::ycc_t ycc
);
  import r2nv_pkg::*;

  logic [17:0] y_sum, cb_sum, cr_sum;
  logic [8:0]  y_val;
  logic [9:0]  cb_val, cr_val;

  // chroma sums stay non-negative thanks to the 128*256 offset
  always_comb begin
    y_sum  = Y_R * 18'(rgb.r) + Y_G * 18'(rgb.g) + Y_B * 18'(rgb.b) + ROUND_OFS;
    cb_sum = CB_B * 18'(rgb.b) + CHROMA_OFS - CB_R * 18'(rgb.r) - CB_G * 18'(rgb.g);
    cr_sum = CR_R * 18'(rgb.r) + CHROMA_OFS - CR_G * 18'(rgb.g) - CR_B * 18'(rgb.b);
    y_val  = 9'(y_sum[17:8]) + 9'(LUMA_MIN);
    cb_val = cb_sum[17:8];
    cr_val = cr_sum[17:8];

    if (y_val < 9'(LUMA_MIN))      ycc.luma = LUMA_MIN;
    else if (y_val > 9'(LUMA_MAX)) ycc.luma = LUMA_MAX;
    else                           ycc.luma = y_val[7:0];

    if (!chroma)                          ycc.cb = '0;
    else if (cb_val < 10'(CHROMA_MIN))    ycc.cb = CHROMA_MIN;
    else if (cb_val > 10'(CHROMA_MAX))    ycc.cb = CHROMA_MAX;
    else                                  ycc.cb = cb_val[7:0];

    if (!chroma)                          ycc.cr = '0;
    else if (cr_val < 10'(CHROMA_MIN))    ycc.cr = CHROMA_MIN;
    else if (cr_val > 10'(CHROMA_MAX))    ycc.cr = CHROMA_MAX;
    else                                  ycc.cr = cr_val[7:0];
  end

endmodule

/* src/rgb_to_nv12_pixel_converter_top.sv */
// Pipeline: an input transaction is captured in the input reg, then in the result reg that drives result valid.
// Throughput: one pixel per cycle; the input stalls only while the result reg is held.
// Rate is set by the single conversion stage between the two pipeline registers.
// Reset (rst_n low, synchronous): pipeline empty, counters at 0, format RGB565,
// frame size 640x480.
module rgb_to_nv12_pixel_converter_top #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  r2nv_pix_in_if.sink    in_bus,
  r2nv_pix_out_if.source out_bus,
  r2nv_cfg_if.sink       cfg_bus
);
  import r2nv_pkg::*;

  logic              fmt_r;
  logic [SIZE_W-1:0] width_r, height_r;

  logic       s1_valid_r;
  rgb_t       s1_rgb_r;
  pos_flags_t s1_flags_r;
  logic       out_valid_r;
  ycc_t       out_ycc_r;
  logic       out_chroma_r, out_end_r;

  rgb_t       in_rgb;
  pos_flags_t pos_flags;
  ycc_t       ycc;
  logic       out_free, s1_move, in_take;

  // config: always ready; the user must write it only while idle (not enforced here)
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_RGB565;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_bus.valid) begin
      unique case (cfg_reg_t'(cfg_bus.index))
        CFG_PIXEL_FORMAT: fmt_r    <= cfg_bus.data[0];
        CFG_FRAME_WIDTH:  width_r  <= cfg_bus.data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_bus.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid_r || out_bus.ready;
  assign s1_move      = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_comb begin
    if (fmt_r == FMT_BGRA) begin
      in_rgb.r = in_bus.pixel_word[23:16];
      in_rgb.g = in_bus.pixel_word[15:8];
      in_rgb.b = in_bus.pixel_word[7:0];
    end else begin
      in_rgb.r = expand5(in_bus.pixel_word[15:11]);
      in_rgb.g = expand6(in_bus.pixel_word[10:5]);
      in_rgb.b = expand5(in_bus.pixel_word[4:0]);
    end
  end

  r2nv_pos_tracker #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_take),
    .frame_width  (width_r),
    .frame_height (height_r),
    .flags        (pos_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_rgb_r   <= in_rgb;
      s1_flags_r <= pos_flags;
    end
  end

  r2nv_csc u_csc (
    .rgb    (s1_rgb_r),
    .chroma (s1_flags_r.chroma),
    .ycc    (ycc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_ycc_r    <= ycc;
      out_chroma_r <= s1_flags_r.chroma;
      out_end_r    <= s1_flags_r.frame_end;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.luma         = out_ycc_r.luma;
  assign out_bus.chroma_valid = out_chroma_r;
  assign out_bus.chroma_blue  = out_ycc_r.cb;
  assign out_bus.chroma_red   = out_ycc_r.cr;
  assign out_bus.frame_end    = out_end_r;

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.chroma_valid |->
      out_bus.chroma_blue == 8'd0 && out_bus.chroma_red == 8'd0)
    else $error("chroma fields nonzero on a non-chroma pixel");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.luma >= LUMA_MIN && out_bus.luma <= LUMA_MAX)
    else $error("luma out of range");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.chroma_valid |->
      out_bus.chroma_blue >= CHROMA_MIN && out_bus.chroma_blue <= CHROMA_MAX &&
      out_bus.chroma_red >= CHROMA_MIN && out_bus.chroma_red <= CHROMA_MAX)
    else $error("chroma out of range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_rgb_r))
    else $error("stalled pipeline item lost");

endmodule

/* tb/rgb_to_nv12_pixel_converter_top_tb.sv */
// Self-checking testbench for the RGB to NV12 pixel converter: predicts Y/Cb/Cr per pixel.
module rgb_to_nv12_pixel_converter_top_tb;
  import r2nv_pkg::*;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       frame_end;
  } nv12_sample_t;

  class nv12_scoreboard;
    logic              fmt;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [11:0]       col;
    logic [11:0]       row;
    nv12_sample_t      expected_q[$];
    int                failures;

    function new();
      fmt = FMT_RGB565;
      width = 13'd640;
      height = 13'd480;
      col = '0;
      row = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PIXEL_FORMAT: fmt = data[0];
        CFG_FRAME_WIDTH:  width = data;
        CFG_FRAME_HEIGHT: height = data;
        default: ;
      endcase
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_size(logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] word);
      int r, g, b, w, h;
      bit col_last, row_last;
      nv12_sample_t s;
      if (fmt == FMT_RGB565) begin
        r = int'(word[15:11]) * 255 / 31;
        g = int'(word[10:5]) * 255 / 63;
        b = int'(word[4:0]) * 255 / 31;
      end else begin
        b = int'(word[7:0]);
        g = int'(word[15:8]);
        r = int'(word[23:16]);
      end
      w = eff_size(width);
      h = eff_size(height);
      s.luma = 8'(clamp(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16, 16, 235));
      s.chroma_valid = !row[0] && !col[0];
      if (s.chroma_valid) begin
        // 128*256 bias keeps the sum non-negative, so the shift floors
        s.cb = 8'(clamp((-38 * r - 74 * g + 112 * b + 128 + 32768) >>> 8, 16, 240));
        s.cr = 8'(clamp((112 * r - 94 * g - 18 * b + 128 + 32768) >>> 8, 16, 240));
      end else begin
        s.cb = '0;
        s.cr = '0;
      end
      col_last = (int'(col) + 1) >= w;
      row_last = (int'(row) + 1) >= h;
      s.frame_end = col_last && row_last;
      if (col_last) begin
        col = '0;
        row = row_last ? 12'd0 : row + 12'd1;
      end else begin
        col = col + 12'd1;
      end
      expected_q.push_back(s);
    endfunction

    function void check_result(nv12_sample_t got);
      nv12_sample_t exp_s;
      if (expected_q.size() == 0) begin
        $error("unexpected output transaction: luma %0d", got.luma);
        failures++;
        return;
      end
      exp_s = expected_q.pop_front();
      if (got.luma !== exp_s.luma) begin
        $error("luma: expected %0d, got %0d", exp_s.luma, got.luma);
        failures++;
      end
      if (got.chroma_valid !== exp_s.chroma_valid) begin
        $error("chroma_valid: expected %0b, got %0b", exp_s.chroma_valid, got.chroma_valid);
        failures++;
      end
      if (got.cb !== exp_s.cb) begin
        $error("chroma_blue: expected %0d, got %0d", exp_s.cb, got.cb);
        failures++;
      end
      if (got.cr !== exp_s.cr) begin
        $error("chroma_red: expected %0d, got %0d", exp_s.cr, got.cr);
        failures++;
      end
      if (got.frame_end !== exp_s.frame_end) begin
        $error("frame_end: expected %0b, got %0b", exp_s.frame_end, got.frame_end);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   out_stall_left;
  int   hang_cycles;

  r2nv_pix_in_if  in_bus();
  r2nv_pix_out_if out_bus();
  r2nv_cfg_if     cfg_bus();

  nv12_scoreboard sb = new();

  rgb_to_nv12_pixel_converter_top #(
    .MAX_DIMENSION(MAX_DIM)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Keeps cfg valid high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic fmt, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    write_reg(CFG_PIXEL_FORMAT, {12'($urandom), fmt});
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_UNMAPPED, 13'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIXEL_W-1:0] word);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.pixel_word <= word;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_pixel(word);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    logic [PIXEL_W-1:0] word;
    logic [7:0] pick;
    word = $urandom;
    // saturated nibbles hit channel extremes and clamp corners
    if ($urandom_range(0, 3) == 0) begin
      pick = 8'($urandom);
      for (int i = 0; i < 8; i++) word[i*4 +: 4] = pick[i] ? 4'hF : 4'h0;
    end
    return word;
  endfunction

  task automatic run_phase(logic fmt, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                           int n, bit idle);
    idle_on = idle;
    configure(fmt, w, h);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    drain();
  endtask

  // Output side: check each transaction and, while idle_on is set, stall ready in random bursts.
  initial begin
    nv12_sample_t got;
    out_stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.luma = out_bus.luma;
        got.chroma_valid = out_bus.chroma_valid;
        got.cb = out_bus.chroma_blue;
        got.cr = out_bus.chroma_red;
        got.frame_end = out_bus.frame_end;
        sb.check_result(got);
      end
      if (out_stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        out_stall_left = $urandom_range(1, 16);
      if (out_stall_left != 0) begin
        out_bus.ready <= 1'b0;
        out_stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Hang detector: cycles without any transaction on any channel.
  initial begin
    hang_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        hang_cycles = 0;
      else
        hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [PIXEL_W-1:0] dir565 [0:10];
    logic [PIXEL_W-1:0] dirbgra [0:10];
    dir565 = '{32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_F800,
               32'h0000_07E0, 32'h0000_001F, 32'h0000_FFE0, 32'h0000_07FF, 32'h0000_0841,
               32'hA5A5_5A5A};
    dirbgra = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000, 32'h00FF_0000,
                32'h0000_FF00, 32'h0000_00FF, 32'h00FF_FF00, 32'h0000_FFFF, 32'h00FF_00FF,
                32'h8010_2030};
    idle_on = 1'b0;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.pixel_word <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_PIXEL_FORMAT;
    cfg_bus.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings (RGB565, 640x480), then BGRA
    foreach (dir565[i]) send_pixel(dir565[i]);
    drain();
    configure(FMT_BGRA, 13'd640, 13'd480);
    foreach (dirbgra[i]) send_pixel(dirbgra[i]);
    drain();

    // zero sizes act as 1x1; oversize acts as the max dimension
    run_phase(FMT_BGRA, 13'd0, 13'd0, 60, 1'b1);
    run_phase(FMT_RGB565, 13'd1, 13'd1, 40, 1'b1);
    run_phase(FMT_BGRA, 13'd2, 13'd2, 70, 1'b1);
    run_phase(FMT_RGB565, 13'd3, 13'd5, 70, 1'b0);
    run_phase(FMT_BGRA, 13'd8191, 13'd2, 60, 1'b1);
    run_phase(FMT_RGB565, 13'd4096, 13'd8191, 40, 1'b1);
    run_phase(FMT_BGRA, 13'd7, 13'd3, 70, 1'b1);
    run_phase(FMT_RGB565, 13'd1, 13'd9, 70, 1'b1);
    run_phase(FMT_BGRA, 13'd6, 13'd1, 70, 1'b1);
    for (int p = 0; p < 4; p++)
      run_phase(1'($urandom), 13'($urandom_range(1, 8)), 13'($urandom_range(1, 8)), 70,
                p < 2);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
